/* sv/edf_pkg.sv */
package edf_pkg;

  localparam int TaskSlots = 16;
  localparam int SlotBits  = 4;
  localparam int TimeBits  = 32;
  localparam int StampBits = 32;

  typedef logic [SlotBits-1:0]  slot_t;
  typedef logic [TimeBits-1:0]  time_t;
  typedef logic [StampBits-1:0] stamp_t;

  typedef enum logic [2:0] {
    REQ_CREATE    = 3'd0,
    REQ_TERMINATE = 3'd1,
    REQ_SET_DL    = 3'd2,
    REQ_SLEEP     = 3'd3,
    REQ_TICK      = 3'd4,
    REQ_LOAD      = 3'd5,
    REQ_BLOCK     = 3'd6,
    REQ_WAKE      = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    PLACE_READY = 2'd0,
    PLACE_SLEEP = 2'd1,
    PLACE_BLOCK = 2'd2
  } place_t;

  // one slot entry as stored in memory
  typedef struct packed {
    logic   used;
    place_t place;
    time_t  deadline;
    time_t  wake;
    stamp_t stamp;
  } entry_t;

  localparam int EntryBits = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PICK,
    ST_EXEC,
    ST_SWEEP,
    ST_PICK2,
    ST_DONE
  } state_t;

endpackage

/* sv/edf_ram.sv */
module edf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/edf_task_scheduler.sv */
// EDF task scheduler.
// Request channel: present in_req_type, in_target_slot, in_deadline_value and
// in_tick_amount with start high while busy is low; the word is taken at
// that edge and busy rises the next cycle.
// Result channel: out_valid pulses for one cycle with out_status,
// out_running_slot, out_created_slot, out_deadline_passed and out_tick_now.
// The receiver cannot stall; the result is shown once.
// A request walks the slot table in one memory several times:
// a scan to find the running slot, the action (a read-modify-write of one
// slot, or a sweep for a create or a tick, two passes for a tick), and a
// final scan. One request at a time; the next word is taken the cycle
// after the result. The table memory's single read port paces every scan.
// Reset: a clearing pass writes every slot entry, one per cycle, holding
// busy high; slot 0 becomes the idle task.
module edf_task_scheduler
  import edf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_req_type,
  input  logic [SlotBits-1:0]  in_target_slot,
  input  logic [TimeBits-1:0]  in_deadline_value,
  input  logic [TimeBits-1:0]  in_tick_amount,
  output logic                 out_valid,
  output logic                 out_status,
  output logic [SlotBits-1:0]  out_running_slot,
  output logic [SlotBits-1:0]  out_created_slot,
  output logic                 out_deadline_passed,
  output logic [TimeBits-1:0]  out_tick_now
);

  localparam int CntBits = SlotBits + 1;

  state_t state_r, state_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic pass_r, pass_nxt;

  req_t  req_r, req_nxt;
  slot_t tgt_r, tgt_nxt;
  time_t dl_r, dl_nxt, amt_r, amt_nxt;

  time_t  tick_r, tick_nxt;
  stamp_t ins_r, ins_nxt;

  slot_t  best_r, best_nxt;
  time_t  bdl_r, bdl_nxt;
  stamp_t bst_r, bst_nxt;
  slot_t  run_r, run_nxt;
  logic   status_r, status_nxt;
  slot_t  created_r, created_nxt;
  logic   found_r, found_nxt;

  logic   we;
  slot_t  waddr, raddr;
  entry_t wdata, rdata;
  entry_t rd_e;

  edf_ram #(.Width(EntryBits), .Depth(TaskSlots)) u_tab (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_e = rdata;

  // entry read in the previous cycle corresponds to slot cnt_r-1
  slot_t cur;
  assign cur = slot_t'(cnt_r - CntBits'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      tick_r  <= '0;
      ins_r   <= StampBits'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tick_r  <= tick_nxt;
      ins_r   <= ins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r    <= pass_nxt;
    req_r     <= req_nxt;
    tgt_r     <= tgt_nxt;
    dl_r      <= dl_nxt;
    amt_r     <= amt_nxt;
    best_r    <= best_nxt;
    bdl_r     <= bdl_nxt;
    bst_r     <= bst_nxt;
    run_r     <= run_nxt;
    status_r  <= status_nxt;
    created_r <= created_nxt;
    found_r   <= found_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pass_nxt    = pass_r;
    req_nxt     = req_r;
    tgt_nxt     = tgt_r;
    dl_nxt      = dl_r;
    amt_nxt     = amt_r;
    tick_nxt    = tick_r;
    ins_nxt     = ins_r;
    best_nxt    = best_r;
    bdl_nxt     = bdl_r;
    bst_nxt     = bst_r;
    run_nxt     = run_r;
    status_nxt  = status_r;
    created_nxt = created_r;
    found_nxt   = found_r;
    we          = 1'b0;
    waddr       = cur;
    wdata       = rd_e;
    raddr       = slot_t'(cnt_r);
    busy        = 1'b1;
    out_valid   = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        we             = 1'b1;
        waddr          = slot_t'(cnt_r);
        wdata          = '0;
        wdata.place    = PLACE_READY;
        if (cnt_r == '0) begin
          wdata.used     = 1'b1;
          wdata.deadline = '1;
        end
        cnt_nxt = cnt_r + CntBits'(1);
        if (cnt_r == CntBits'(TaskSlots - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          req_nxt   = req_t'(in_req_type);
          tgt_nxt   = in_target_slot;
          dl_nxt    = in_deadline_value;
          amt_nxt   = in_tick_amount;
          cnt_nxt   = '0;
          state_nxt = ST_PICK;
        end
      end
      ST_PICK, ST_PICK2: begin
        raddr   = slot_t'(cnt_r);
        cnt_nxt = cnt_r + CntBits'(1);
        if (cnt_r == CntBits'(1)) begin
          best_nxt = '0;
          bdl_nxt  = rd_e.deadline;
          bst_nxt  = rd_e.stamp;
        end else if (cnt_r != '0) begin
          if (rd_e.used && rd_e.place == PLACE_READY &&
              (rd_e.deadline < bdl_r ||
               (rd_e.deadline == bdl_r && rd_e.stamp > bst_r))) begin
            best_nxt = cur;
            bdl_nxt  = rd_e.deadline;
            bst_nxt  = rd_e.stamp;
          end
        end
        if (cnt_r == CntBits'(TaskSlots)) begin
          cnt_nxt = '0;
          if (state_r == ST_PICK) begin
            run_nxt     = best_nxt;
            status_nxt  = 1'b0;
            created_nxt = '0;
            found_nxt   = 1'b0;
            pass_nxt    = 1'b0;
            if (req_r == REQ_TICK) begin
              tick_nxt  = tick_r + TimeBits'(1);
              cnt_nxt   = CntBits'(1);
              state_nxt = ST_SWEEP;
            end else if (req_r == REQ_CREATE) begin
              cnt_nxt   = CntBits'(1);
              state_nxt = ST_SWEEP;
            end else begin
              state_nxt = ST_EXEC;
            end
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_EXEC: begin
        // with cnt_r at 0 the read of the affected slot is issued; with cnt_r at 1 it is written back
        raddr = (req_r == REQ_WAKE) ? tgt_r : run_r;
        if (cnt_r == '0) begin
          cnt_nxt = CntBits'(1);
        end else begin
          waddr   = raddr;
          wdata   = rd_e;
          cnt_nxt = '0;
          state_nxt = ST_PICK2;
          case (req_r)
            REQ_LOAD: begin
              tick_nxt = amt_r;
            end
            REQ_WAKE: begin
              if (tgt_r == '0 || !rd_e.used || rd_e.place != PLACE_BLOCK) begin
                status_nxt = 1'b1;
              end else begin
                we          = 1'b1;
                wdata.place = PLACE_READY;
                wdata.stamp = ins_r;
                ins_nxt     = ins_r + StampBits'(1);
              end
            end
            default: begin
              if (run_r == '0) begin
                status_nxt = 1'b1;
              end else begin
                we = 1'b1;
                case (req_r)
                  REQ_TERMINATE: begin
                    wdata.used  = 1'b0;
                    wdata.place = PLACE_READY;
                  end
                  REQ_SET_DL: begin
                    wdata.deadline = dl_r;
                    wdata.place    = PLACE_READY;
                    wdata.stamp    = ins_r;
                    ins_nxt        = ins_r + StampBits'(1);
                  end
                  REQ_SLEEP: begin
                    wdata.wake  = tick_r + amt_r;
                    wdata.place = PLACE_SLEEP;
                  end
                  default: begin
                    wdata.place = PLACE_BLOCK;
                  end
                endcase
              end
            end
          endcase
        end
      end
      ST_SWEEP: begin
        // read slot cnt, examine slot cnt-1 (slots 1..N-1)
        raddr   = slot_t'(cnt_r);
        cnt_nxt = cnt_r + CntBits'(1);
        if (cnt_r >= CntBits'(2)) begin
          if (req_r == REQ_CREATE) begin
            if (!found_r && !rd_e.used) begin
              we             = 1'b1;
              wdata          = rd_e;
              wdata.used     = 1'b1;
              wdata.deadline = dl_r;
              wdata.wake     = '0;
              wdata.place    = PLACE_READY;
              wdata.stamp    = ins_r;
              ins_nxt        = ins_r + StampBits'(1);
              found_nxt      = 1'b1;
              created_nxt    = cur;
            end
          end else if (rd_e.used &&
                       ((!pass_r && rd_e.place == PLACE_SLEEP &&
                         (rd_e.deadline <= tick_r || rd_e.wake <= tick_r)) ||
                        (pass_r && rd_e.place == PLACE_BLOCK &&
                         rd_e.deadline <= tick_r))) begin
            we          = 1'b1;
            wdata       = rd_e;
            wdata.place = PLACE_READY;
            wdata.stamp = ins_r;
            ins_nxt     = ins_r + StampBits'(1);
          end
        end
        if (cnt_r == CntBits'(TaskSlots)) begin
          if (req_r == REQ_TICK && !pass_r) begin
            pass_nxt = 1'b1;
            cnt_nxt  = CntBits'(1);
          end else begin
            if (req_r == REQ_CREATE) begin
              status_nxt = !found_nxt;
            end
            cnt_nxt   = '0;
            state_nxt = ST_PICK2;
          end
        end
      end
      ST_DONE: begin
        // read back the running slot deadline
        raddr = best_r;
        if (cnt_r == '0) begin
          cnt_nxt = CntBits'(1);
        end else begin
          out_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sweep writes trail reads by one slot, so no same-entry overlap arises
  assign out_status          = status_r;
  assign out_running_slot    = best_r;
  assign out_created_slot    = created_r;
  assign out_deadline_passed = rd_e.deadline <= tick_r;
  assign out_tick_now        = tick_r;

endmodule

/* sv/edf_checker.sv */
module edf_checker
  import edf_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic                out_status,
  input logic [SlotBits-1:0] out_created_slot
);

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");

  a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy after result");

  a_no_pulse_twice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("double result");

  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> out_created_slot == '0)
    else $error("slot on fail");

  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request not taken");

endmodule

bind edf_task_scheduler edf_checker u_edf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_created_slot (out_created_slot)
);

/* test/tb_edf_task_scheduler.sv */
module tb_edf_task_scheduler;
  import edf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0] req;
    slot_t      target;
    time_t      dl;
    time_t      amt;
  } word_t;

  typedef struct {
    logic  status;
    slot_t running;
    slot_t created;
    logic  passed;
    time_t tick;
  } reply_t;

  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_req_type = '0;
  slot_t in_target_slot = '0;
  time_t in_deadline_value = '0;
  time_t in_tick_amount = '0;
  logic out_valid;
  logic out_status;
  slot_t out_running_slot;
  slot_t out_created_slot;
  logic out_deadline_passed;
  time_t out_tick_now;

  edf_task_scheduler dut (.*);

  always #10 clk = ~clk;

  logic   m_used [TaskSlots];
  place_t m_place [TaskSlots];
  time_t  m_dl [TaskSlots];
  time_t  m_wake [TaskSlots];
  stamp_t m_stamp [TaskSlots];
  stamp_t m_insert;
  time_t  m_tick;
  time_t  m_tick_guess = '0;

  word_t  pending_words[$];
  reply_t expected_replies[$];
  int errors = 0;
  int accepted = 0;
  int replies = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit hold_off = 1'b0;
  int req_seen [8];

  function automatic void sched_reset();
    for (int i = 0; i < TaskSlots; i++) begin
      m_used[i] = 1'b0; m_place[i] = PLACE_READY; m_dl[i] = '0;
      m_wake[i] = '0; m_stamp[i] = '0;
    end
    m_used[0] = 1'b1;
    m_dl[0] = '1;
    m_insert = 1;
    m_tick = '0;
  endfunction

  function automatic void ready_slot(int s);
    m_place[s] = PLACE_READY;
    m_stamp[s] = m_insert;
    m_insert = m_insert + 1;
  endfunction

  function automatic int earliest_ready();
    int best;
    best = 0;
    for (int i = 1; i < TaskSlots; i++) begin
      if (!m_used[i] || m_place[i] != PLACE_READY) continue;
      if (m_dl[i] < m_dl[best] || (m_dl[i] == m_dl[best] && m_stamp[i] > m_stamp[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic reply_t sched_step(word_t w);
    reply_t r;
    int run;
    r.status = 1'b0;
    r.created = '0;
    run = earliest_ready();
    case (req_t'(w.req))
      REQ_CREATE: begin
        r.status = 1'b1;
        for (int i = 1; i < TaskSlots; i++) begin
          if (!m_used[i]) begin
            m_used[i] = 1'b1; m_dl[i] = w.dl; m_wake[i] = '0;
            ready_slot(i);
            r.created = slot_t'(i);
            r.status = 1'b0;
            break;
          end
        end
      end
      REQ_TERMINATE, REQ_SET_DL, REQ_SLEEP, REQ_BLOCK: begin
        if (run == 0) r.status = 1'b1;
        else if (req_t'(w.req) == REQ_TERMINATE) begin
          m_used[run] = 1'b0; m_place[run] = PLACE_READY;
        end else if (req_t'(w.req) == REQ_SET_DL) begin
          m_dl[run] = w.dl; ready_slot(run);
        end else if (req_t'(w.req) == REQ_SLEEP) begin
          m_wake[run] = m_tick + w.amt; m_place[run] = PLACE_SLEEP;
        end else m_place[run] = PLACE_BLOCK;
      end
      REQ_TICK: begin
        m_tick = m_tick + 1;
        for (int i = 1; i < TaskSlots; i++)
          if (m_used[i] && m_place[i] == PLACE_SLEEP &&
              (m_dl[i] <= m_tick || m_wake[i] <= m_tick)) ready_slot(i);
        for (int i = 1; i < TaskSlots; i++)
          if (m_used[i] && m_place[i] == PLACE_BLOCK && m_dl[i] <= m_tick) ready_slot(i);
      end
      REQ_LOAD: m_tick = w.amt;
      default: begin
        if (w.target == '0 || !m_used[w.target] || m_place[w.target] != PLACE_BLOCK)
          r.status = 1'b1;
        else ready_slot(w.target);
      end
    endcase
    run = earliest_ready();
    r.running = slot_t'(run);
    r.passed = (m_dl[run] <= m_tick);
    r.tick = m_tick;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_replies.push_back(sched_step(
          '{in_req_type, in_target_slot, in_deadline_value, in_tick_amount}));
        req_seen[in_req_type]++;
        accepted++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_words.size() > 0 && !hold_off) begin
          word_t w;
          w = pending_words.pop_front();
          in_req_type <= w.req;
          in_target_slot <= w.target;
          in_deadline_value <= w.dl;
          in_tick_amount <= w.amt;
          start <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        reply_t e;
        replies++;
        if (expected_replies.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          e = expected_replies.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++;
          end
          if (out_running_slot !== e.running) begin
            $error("running_slot exp %0d got %0d", e.running, out_running_slot); errors++;
          end
          if (out_created_slot !== e.created) begin
            $error("created_slot exp %0d got %0d", e.created, out_created_slot); errors++;
          end
          if (out_deadline_passed !== e.passed) begin
            $error("deadline_passed exp %0d got %0d", e.passed, out_deadline_passed);
            errors++;
          end
          if (out_tick_now !== e.tick) begin
            $error("tick_now exp %0h got %0h", e.tick, out_tick_now); errors++;
          end
        end
      end
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no progress, %0d results outstanding", expected_replies.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic time_t rand_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return time_t'($urandom_range(0, 8));
      3: return 32'hFFFF_FFF0 + time_t'($urandom_range(0, 15));
      default: return time_t'($urandom());
    endcase
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int k;
    k = $urandom_range(0, 99);
    if (k < 18) w.req = REQ_CREATE;
    else if (k < 26) w.req = REQ_TERMINATE;
    else if (k < 36) w.req = REQ_SET_DL;
    else if (k < 48) w.req = REQ_SLEEP;
    else if (k < 72) w.req = REQ_TICK;
    else if (k < 76) w.req = REQ_LOAD;
    else if (k < 86) w.req = REQ_BLOCK;
    else w.req = REQ_WAKE;
    w.target = slot_t'($urandom());
    w.dl = ($urandom_range(0, 3) == 0) ? rand_time() : m_tick_guess + $urandom_range(0, 30);
    w.amt = ($urandom_range(0, 4) == 0) ? rand_time() : time_t'($urandom_range(0, 6));
    if (w.req == REQ_LOAD && $urandom_range(0, 1)) w.amt = 32'hFFFF_FFF8;
    return w;
  endfunction

  task automatic queue_word(logic [2:0] rq, slot_t tg, time_t dl, time_t amt);
    pending_words.push_back('{rq, tg, dl, amt});
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || start) @(posedge clk);
    while (expected_replies.size() > 0) @(posedge clk);
  endtask

  initial begin
    sched_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_word(REQ_TERMINATE, '0, '0, '0);
    queue_word(REQ_SET_DL, '0, 32'd5, '0);
    queue_word(REQ_SLEEP, '0, '0, 32'd3);
    queue_word(REQ_BLOCK, '0, '0, '0);
    queue_word(REQ_WAKE, '0, '0, '0);
    queue_word(REQ_WAKE, 4'hF, '1, '1);
    for (int i = 0; i < 16; i++) queue_word(REQ_CREATE, slot_t'(i), time_t'(100 + (i % 3)), '0);
    queue_word(REQ_BLOCK, '0, '0, '0);
    queue_word(REQ_WAKE, 4'd1, '0, '0);
    queue_word(REQ_LOAD, '0, '0, '1);
    queue_word(REQ_TICK, '0, '0, '0);
    queue_word(REQ_SLEEP, '0, '0, '1);
    drain();

    hold_off = 1'b1;
    repeat (4 * TaskSlots + 20) @(posedge clk);
    hold_off = 1'b0;

    for (int n = 0; n < 2000; n++) begin
      if (n % 64 == 0) m_tick_guess = m_tick;
      pending_words.push_back(rand_word());
      if (n == 1000) begin
        drain();
        hold_off = 1'b1;
        repeat ($urandom_range(1, 50)) @(posedge clk);
        hold_off = 1'b0;
      end
      if (pending_words.size() > 8) @(posedge clk);
    end
    drain();
    repeat (4 * TaskSlots + 20) @(posedge clk);

    $display("covered %0d requests, %0d results; creates %0d ticks %0d wakes %0d",
             accepted, replies, req_seen[REQ_CREATE], req_seen[REQ_TICK], req_seen[REQ_WAKE]);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
